// File: rtl/core/tpot_pkg.sv
// ----------------------------------------------------------------------------
// tpot_pkg: shared definitions for the timestamp pair offset tracker
// Widths, opcodes, status codes, register map and the structs that travel
// between the configuration block, the tracker datapath and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package tpot_pkg;

   localparam int HISTORY_DEPTH = 4;

   localparam int TIME_W   = 63;
   localparam int OFFSET_W = 64;
   localparam int CFG_W    = 16;
   localparam int COUNT_W  = 16;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;
   localparam int ADDR_W   = 3;
   localparam int DATA_W   = 32;

   localparam logic [OP_W-1:0] OP_LOCAL   = 2'd0;
   localparam logic [OP_W-1:0] OP_FRAME   = 2'd1;
   localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_VALID   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_ERROR   = 2'd2;

   localparam logic REG_MAX_DELTA_ERROR = 1'b0;
   localparam logic REG_ERROR_LIMIT     = 1'b1;

   localparam logic [CFG_W-1:0] MAX_DELTA_ERROR_RESET = 16'd100;
   localparam logic [CFG_W-1:0] ERROR_LIMIT_RESET     = 16'd10;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   typedef struct packed {
      logic [CFG_W-1:0] max_delta_error;
      logic [CFG_W-1:0] error_limit;
   } cfg_type;

   typedef struct packed {
      logic [OFFSET_W-1:0] offset;
      logic [STATUS_W-1:0] offset_status;
      logic                sync_fault;
   } result_type;

endpackage

`default_nettype wire

// File: rtl/core/tpot_csr.sv
// ----------------------------------------------------------------------------
// tpot_csr: configuration registers
// APB-style register file holding the period tolerance and the consecutive
// error limit. Register index is taken from address bit 2.
// ----------------------------------------------------------------------------
`default_nettype none

module tpot_csr
   import tpot_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [ADDR_W-1:0] csr_paddr,
   input  wire logic [DATA_W-1:0] csr_pwdata,
   output logic      [DATA_W-1:0] csr_prdata,
   output logic                   csr_pready,
   output cfg_type                cfg
);

   logic [CFG_W-1:0] max_delta_ff;
   logic [CFG_W-1:0] max_delta_in;
   logic [CFG_W-1:0] max_errors_ff;
   logic [CFG_W-1:0] max_errors_in;
   logic             wr_en;
   logic             reg_sel;

   assign csr_pready = 1'b1;
   assign reg_sel    = csr_paddr[2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      max_delta_in  = max_delta_ff;
      max_errors_in = max_errors_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_MAX_DELTA_ERROR: max_delta_in  = csr_pwdata[CFG_W-1:0];
            REG_ERROR_LIMIT:     max_errors_in = csr_pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_delta_ff  <= MAX_DELTA_ERROR_RESET;
         max_errors_ff <= ERROR_LIMIT_RESET;
      end else begin
         max_delta_ff  <= max_delta_in;
         max_errors_ff <= max_errors_in;
      end
   end

   always_comb begin
      case (reg_sel)
         REG_MAX_DELTA_ERROR: csr_prdata = {{(DATA_W-CFG_W){1'b0}}, max_delta_ff};
         REG_ERROR_LIMIT:     csr_prdata = {{(DATA_W-CFG_W){1'b0}}, max_errors_ff};
         default:             csr_prdata = '0;
      endcase
   end

   assign cfg.max_delta_error = max_delta_ff;
   assign cfg.error_limit     = max_errors_ff;

endmodule

`default_nettype wire

// File: rtl/core/tpot_tracker.sv
// ----------------------------------------------------------------------------
// tpot_tracker: timestamp history, frame judgment and offset state
// History is a rotating line of paired stamps: tap 0 is the current slot,
// tap 1 the previous one, tap 2 the one before. A frame rotates the line.
// ----------------------------------------------------------------------------
`default_nettype none

module tpot_tracker
   import tpot_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire logic [OP_W-1:0]   op,
   input  wire logic [TIME_W-1:0] time_us,
   input  wire cfg_type           cfg,
   output result_type             result
);

   logic [TIME_W-1:0]   loc_ff [HISTORY_DEPTH];
   logic [TIME_W-1:0]   loc_in [HISTORY_DEPTH];
   logic [TIME_W-1:0]   ref_ff [HISTORY_DEPTH];
   logic [TIME_W-1:0]   ref_in [HISTORY_DEPTH];
   logic [COUNT_W-1:0]  err_ff;
   logic [COUNT_W-1:0]  err_in;
   logic [OFFSET_W-1:0] offset_ff;
   logic [OFFSET_W-1:0] offset_in;
   logic [STATUS_W-1:0] status_ff;
   logic [STATUS_W-1:0] status_in;

   logic                is_frame;
   logic                is_local;
   logic                is_restart;
   logic                pair_ok;
   logic                pprev_ok;
   logic [OFFSET_W:0]   e_diff;
   logic [OFFSET_W:0]   p_diff;
   logic                e_pos;
   logic                p_pos;
   logic [OFFSET_W-1:0] e_mag;
   logic [OFFSET_W-1:0] p_mag;
   logic [OFFSET_W-1:0] s_mag;
   logic [CFG_W:0]      tol2;
   logic                accept;
   logic                fault;

   // exact (a_here + b_prev) - (a_prev + b_here), 65 bits signed
   function automatic logic [OFFSET_W:0] period_diff(
      input logic [TIME_W-1:0] l_here,
      input logic [TIME_W-1:0] l_prev,
      input logic [TIME_W-1:0] r_here,
      input logic [TIME_W-1:0] r_prev
   );
      logic [OFFSET_W-1:0] sum_a;
      logic [OFFSET_W-1:0] sum_b;
      sum_a = {1'b0, l_here} + {1'b0, r_prev};
      sum_b = {1'b0, l_prev} + {1'b0, r_here};
      return {1'b0, sum_a} - {1'b0, sum_b};
   endfunction

   assign is_local   = step && (op == OP_LOCAL);
   assign is_frame   = step && (op == OP_FRAME);
   assign is_restart = step && (op == OP_RESTART);

   assign pair_ok  = (loc_ff[0] != '0) && (loc_ff[1] != '0) &&
                     (time_us != '0) && (ref_ff[1] != '0);
   assign pprev_ok = (loc_ff[2] != '0) && (ref_ff[2] != '0);

   assign e_diff = period_diff(loc_ff[0], loc_ff[1], time_us, ref_ff[1]);
   assign p_diff = period_diff(loc_ff[1], loc_ff[2], ref_ff[1], ref_ff[2]);
   assign e_pos  = !e_diff[OFFSET_W] && (e_diff != '0);
   assign p_pos  = !p_diff[OFFSET_W] && (p_diff != '0);
   assign e_mag  = e_diff[OFFSET_W] ? OFFSET_W'(-e_diff) : e_diff[OFFSET_W-1:0];
   assign p_mag  = p_diff[OFFSET_W] ? OFFSET_W'(-p_diff) : p_diff[OFFSET_W-1:0];
   assign s_mag  = (p_mag >= e_mag) ? (p_mag - e_mag) : (e_mag - p_mag);
   assign tol2   = {cfg.max_delta_error, 1'b0};

   assign accept = pair_ok &&
      ((e_mag <= {{(OFFSET_W-CFG_W){1'b0}}, cfg.max_delta_error}) ||
       (pprev_ok && !e_pos && p_pos &&
        (s_mag <= {{(OFFSET_W-CFG_W-1){1'b0}}, tol2})));

   always_comb begin
      loc_in    = loc_ff;
      ref_in    = ref_ff;
      err_in    = err_ff;
      offset_in = offset_ff;
      status_in = status_ff;
      fault     = 1'b0;
      if (is_local) begin
         loc_in[0] = time_us;
      end else if (is_frame) begin
         // advance the ring: the just completed slot becomes the previous one
         loc_in[0] = loc_ff[HISTORY_DEPTH-1];
         ref_in[0] = ref_ff[HISTORY_DEPTH-1];
         for (int k = 1; k < HISTORY_DEPTH; k++) begin
            loc_in[k] = loc_ff[k-1];
            ref_in[k] = ref_ff[k-1];
         end
         ref_in[1] = time_us;
         if (accept) begin
            offset_in = {1'b0, loc_ff[0]} - {1'b0, time_us};
            status_in = STATUS_VALID;
            err_in    = '0;
         end else if (err_ff != COUNT_MAX) begin
            err_in = err_ff + COUNT_W'(1);
         end
         if ((err_in != '0) && (err_in >= cfg.error_limit)) begin
            status_in = STATUS_ERROR;
            fault     = 1'b1;
         end
      end else if (is_restart) begin
         for (int k = 0; k < HISTORY_DEPTH; k++) begin
            loc_in[k] = '0;
            ref_in[k] = '0;
         end
         err_in    = '0;
         offset_in = '0;
         status_in = STATUS_INVALID;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < HISTORY_DEPTH; k++) begin
            loc_ff[k] <= '0;
            ref_ff[k] <= '0;
         end
         err_ff    <= '0;
         offset_ff <= '0;
         status_ff <= STATUS_INVALID;
      end else begin
         loc_ff    <= loc_in;
         ref_ff    <= ref_in;
         err_ff    <= err_in;
         offset_ff <= offset_in;
         status_ff <= status_in;
      end
   end

   assign result.offset        = offset_in;
   assign result.offset_status = status_in;
   assign result.sync_fault    = fault;

   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      is_restart |=> (status_ff == STATUS_INVALID) && (err_ff == '0) && (offset_ff == '0))
      else $error("restart did not clear tracker state");

   a_local_holds: assert property (@(posedge clock) disable iff (reset)
      is_local |=> $stable(err_ff) && $stable(status_ff) && $stable(offset_ff))
      else $error("local edge changed offset state");

   a_reject_counts: assert property (@(posedge clock) disable iff (reset)
      (is_frame && !accept) |=> (err_ff != '0))
      else $error("rejected frame left error count at zero");

   a_fault_status: assert property (@(posedge clock) disable iff (reset)
      (is_frame && fault) |=> (status_ff == STATUS_ERROR))
      else $error("sync fault without error status");

endmodule

`default_nettype wire

// File: rtl/core/timestamp_pair_offset_tracker_core.sv
// ----------------------------------------------------------------------------
// timestamp_pair_offset_tracker_core: local to reference clock offset tracker
// Input register, tracker datapath, result register, configuration port.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries one transaction per item: opcode (local edge,
//   reference frame, restart) and a 63-bit microsecond timestamp.
//   rsp channel returns exactly one transaction per request: current offset,
//   offset status and the sync fault flag of a reference frame.
//   csr port holds the period tolerance (address 0) and the consecutive
//   error limit (address 4); write it only while no transaction is in flight.
// Path: a request waits in the input register, then passes through the judge
//   into the result register, which drives rsp_valid and the response; a
//   stall can hold it in either register.
// Throughput: one transaction per cycle while rsp_stall is low, as the judge
//   between the input and result registers is combinational.
// Reset: clears the history ring, error count, offset and status (invalid)
//   and loads register defaults; no clearing pass, usable next cycle.
// Stall: while rsp_stall is high the result holds; the input register keeps
//   one more transaction and then req_stall rises until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module timestamp_pair_offset_tracker_core
   import tpot_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [OP_W-1:0]       req_opcode,
   input  wire logic [TIME_W-1:0]     req_time_us,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic signed [OFFSET_W-1:0] rsp_offset,
   output logic [STATUS_W-1:0]        rsp_offset_status,
   output logic                       rsp_sync_fault,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [ADDR_W-1:0]     csr_paddr,
   input  wire logic [DATA_W-1:0]     csr_pwdata,
   output logic      [DATA_W-1:0]     csr_prdata,
   output logic                       csr_pready
);

   cfg_type           cfg;
   result_type        result;

   logic              in_valid_ff;
   logic              in_valid_in;
   logic [OP_W-1:0]   in_op_ff;
   logic [TIME_W-1:0] in_time_ff;
   logic              out_valid_ff;
   logic              out_valid_in;
   result_type        out_ff;
   logic              advance;
   logic              req_take;
   logic              rsp_take;

   tpot_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tpot_tracker u_tracker (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .op      (in_op_ff),
      .time_us (in_time_ff),
      .cfg     (cfg),
      .result  (result)
   );

   assign rsp_take  = out_valid_ff && !rsp_stall;
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff   <= req_opcode;
         in_time_ff <= req_time_us;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_offset        = out_ff.offset;
   assign rsp_offset_status = out_ff.offset_status;
   assign rsp_sync_fault    = out_ff.sync_fault;

endmodule

`default_nettype wire
